// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define U2L_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define U2L_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/u2l_pkg.sv =====
package u2l_pkg;

   // Characters that the decoder treats specially.
   localparam logic [7:0] Backslash    = 8'h5C;
   localparam logic [7:0] QuestionMark = 8'h3F;
   localparam logic [7:0] Newline      = 8'h0A;
   localparam logic [7:0] LetterN      = 8'h6E;

   // One request yields at most this many output bytes.
   localparam int MaxResults       = 4;
   localparam int ResultCountWidth = $clog2(MaxResults + 1);

   // Queue between the decoder and the output stage.
   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // All output bytes produced by one request.
   typedef struct packed {
      logic [MaxResults-1:0][7:0]    data;
      logic [ResultCountWidth-1:0]   count;
      logic                          last;
   } bundle_type;

endpackage

// ===== design/u2l_req_if.sv =====
interface u2l_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       field_last;

   modport source (output valid, output in_byte, output field_last, input ready);
   modport sink (input valid, input in_byte, input field_last, output ready);
endinterface

// ===== design/u2l_rsp_if.sv =====
interface u2l_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== design/u2l_fifo.sv =====
`include "assert_macros.svh"

module u2l_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  u2l_pkg::bundle_type push_bundle,
   output logic                push_ready,
   output logic                pop_valid,
   output u2l_pkg::bundle_type pop_bundle,
   input  logic                pop_ready
);
   import u2l_pkg::*;

   bundle_type                 mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   // Flags come straight from the registered fill count.
   assign push_ready = (count_ff != QueueCountWidth'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_bundle = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   `U2L_ASSERT_SAME(a_fifo_no_overflow, push_valid, push_ready, "bundle pushed into a full queue")

endmodule

// ===== design/u2l_front.sv =====
`include "assert_macros.svh"

module u2l_front (
   input  logic                clock,
   input  logic                reset,
   u2l_req_if.sink             req_ch,
   output logic                push_valid,
   output u2l_pkg::bundle_type push_bundle,
   input  logic                push_ready
);
   import u2l_pkg::*;

   // Held state between requests.
   logic [7:0]                  pend_ff [3];
   logic [7:0]                  pend_in [3];
   logic [1:0]                  count_ff, count_in;
   logic                        esc_ff, esc_in;

   logic                        accept;
   logic                        fld_last;
   logic [7:0]                  q [MaxResults];
   logic [2:0]                  n, head, avail, rem, chk;
   logic [ResultCountWidth-1:0] nout;
   logic                        stop, ok;
   logic [1:0]                  need;
   logic [7:0]                  c, b1, b2, b3;
   logic [MaxResults-1:0][7:0]  emit;

   function automatic logic is_cont(input logic [7:0] b);
      return (b[7:6] == 2'b10);
   endfunction

   // Continuation bytes a lead byte asks for; zero marks an invalid lead.
   function automatic logic [1:0] cont_needed(input logic [7:0] b);
      logic [1:0] res;
      res = 2'd0;
      if (b[7:5] == 3'b110) begin
         res = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         res = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         res = 2'd3;
      end
      return res;
   endfunction

   assign fld_last     = req_ch.field_last;
   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Work queue: a held backslash or the held sequence bytes, then the new byte.
   always_comb begin
      for (int i = 0; i < MaxResults; i++) begin
         q[i] = 8'h00;
      end
      if (esc_ff) begin
         q[0] = Backslash;
         q[1] = req_ch.in_byte;
         n    = 3'd2;
      end else begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < count_ff) begin
               q[i] = pend_ff[i];
            end
         end
         q[count_ff] = req_ch.in_byte;
         n           = {1'b0, count_ff} + 3'd1;
      end
   end

   // Decode the work queue, one output byte for each step.
   always_comb begin
      head  = 3'd0;
      nout  = '0;
      stop  = 1'b0;
      emit  = '0;
      c     = 8'h00;
      b1    = 8'h00;
      b2    = 8'h00;
      b3    = 8'h00;
      avail = 3'd0;
      need  = 2'd0;
      chk   = 3'd0;
      ok    = 1'b0;
      for (int s = 0; s < MaxResults; s++) begin
         if (!stop && (head < n)) begin
            c     = q[head[1:0]];
            b1    = q[head[1:0] + 2'd1];
            b2    = q[head[1:0] + 2'd2];
            b3    = q[head[1:0] + 2'd3];
            avail = n - head - 3'd1;
            if (c == Backslash) begin
               if (avail == 3'd0) begin
                  // A lone backslash waits for its partner unless the field ends.
                  if (!fld_last) begin
                     stop = 1'b1;
                  end else begin
                     emit[s] = Backslash;
                     head    = head + 3'd1;
                     nout    = nout + 1'b1;
                  end
               end else if (b1 == LetterN) begin
                  emit[s] = Newline;
                  head    = head + 3'd2;
                  nout    = nout + 1'b1;
               end else if (b1 == Backslash) begin
                  emit[s] = Backslash;
                  head    = head + 3'd2;
                  nout    = nout + 1'b1;
               end else begin
                  emit[s] = Backslash;
                  head    = head + 3'd1;
                  nout    = nout + 1'b1;
               end
            end else if (!c[7]) begin
               emit[s] = c;
               head    = head + 3'd1;
               nout    = nout + 1'b1;
            end else begin
               need = cont_needed(c);
               chk  = (avail < {1'b0, need}) ? avail : {1'b0, need};
               ok   = (need != 2'd0);
               if ((chk >= 3'd1) && !is_cont(b1)) ok = 1'b0;
               if ((chk >= 3'd2) && !is_cont(b2)) ok = 1'b0;
               if ((chk >= 3'd3) && !is_cont(b3)) ok = 1'b0;
               if (!ok) begin
                  // Broken sequence or invalid lead: replace only the lead with a question mark.
                  emit[s] = QuestionMark;
                  head    = head + 3'd1;
                  nout    = nout + 1'b1;
               end else if (avail < {1'b0, need}) begin
                  if (!fld_last) begin
                     stop = 1'b1;
                  end else begin
                     emit[s] = QuestionMark;
                     head    = head + 3'd1;
                     nout    = nout + 1'b1;
                  end
               end else begin
                  unique case (need)
                     2'd1: begin
                        emit[s] = (c[4:2] == 3'b000) ? {c[1:0], b1[5:0]} : QuestionMark;
                     end
                     2'd2: begin
                        emit[s] = ((c[3:0] == 4'h0) && (b1[5:2] == 4'h0)) ?
                                  {b1[1:0], b2[5:0]} : QuestionMark;
                     end
                     default: begin
                        emit[s] = QuestionMark;
                     end
                  endcase
                  head = head + {1'b0, need} + 3'd1;
                  nout = nout + 1'b1;
               end
            end
         end
      end
   end

   // Whatever is left over becomes the held state for the next request.
   always_comb begin
      esc_in   = 1'b0;
      count_in = 2'd0;
      rem      = 3'd0;
      for (int i = 0; i < 3; i++) begin
         pend_in[i] = pend_ff[i];
      end
      if (head < n) begin
         rem = n - head;
         if ((rem == 3'd1) && (q[head[1:0]] == Backslash)) begin
            esc_in = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (3'(i) < rem) begin
                  pend_in[i] = q[head[1:0] + 2'(i)];
               end
            end
            count_in = (rem > 3'd3) ? 2'd3 : rem[1:0];
         end
      end
   end

   assign push_valid        = accept && (nout != '0);
   assign push_bundle.data  = emit;
   assign push_bundle.count = nout;
   assign push_bundle.last  = fld_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         esc_ff   <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         esc_ff   <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            pend_ff[i] <= pend_in[i];
         end
      end
   end

   `U2L_ASSERT_SAME(a_front_esc_excl, esc_ff, count_ff == 2'd0, "backslash and sequence both held")
   `U2L_ASSERT_SAME(a_front_last_push, accept && fld_last, push_valid, "field end gave no output")
   `U2L_ASSERT_NEXT(a_front_last_clear, accept && fld_last, (count_ff == 2'd0) && !esc_ff, "state held past field end")

endmodule

// ===== design/u2l_back.sv =====
`include "assert_macros.svh"

module u2l_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  u2l_pkg::bundle_type pop_bundle,
   output logic                pop_ready,
   u2l_rsp_if.source           rsp_ch
);
   import u2l_pkg::*;

   logic [1:0]                  idx_ff, idx_in;
   logic [ResultCountWidth-1:0] idx_ext;
   logic                        bundle_end;
   logic                        rsp_accept;

   assign idx_ext    = ResultCountWidth'(idx_ff);
   assign bundle_end = (idx_ext == (pop_bundle.count - 1'b1));

   // Present the current byte of the head bundle.
   assign rsp_ch.valid    = pop_valid;
   assign rsp_ch.out_byte = pop_bundle.data[idx_ff];
   assign rsp_ch.out_last = pop_bundle.last && bundle_end;

   assign rsp_accept = rsp_ch.valid && rsp_ch.ready;
   assign pop_ready  = rsp_accept && bundle_end;

   // Step through the bundle and release it after its final byte.
   always_comb begin
      idx_in = idx_ff;
      if (rsp_accept) begin
         idx_in = bundle_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `U2L_ASSERT_SAME(a_back_idx_range, pop_valid, idx_ext < pop_bundle.count, "byte index beyond bundle")

endmodule

// ===== design/utf8_to_latin1_unescape.sv =====
// Channel   Direction  Handshake          Payload
// req_ch    in         valid / ready      in_byte[7:0], field_last
// rsp_ch    out        valid / ready      out_byte[7:0], out_last
//
// A request is taken every cycle while the four-entry bundle queue has room;
// the decoder handles one byte per cycle and its output bundle is registered in the
// queue. Each request yields zero to four output bytes, sent one per cycle while
// rsp_ch is ready, so a request flushing a broken sequence holds up to four bytes.
// Reset is synchronous and empties the queue and the held escape and sequence state.
// A stall on rsp_ch reaches req_ch only once the queue has filled.
module utf8_to_latin1_unescape (
   input logic       clock,
   input logic       reset,
   u2l_req_if.sink   req_ch,
   u2l_rsp_if.source rsp_ch
);
   import u2l_pkg::*;

   logic       push_valid, push_ready;
   logic       pop_valid, pop_ready;
   bundle_type push_bundle, pop_bundle;

   // Decoder: classifies each byte and forms its output bundle.
   u2l_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready)
   );

   // Queue that decouples decoding from output.
   u2l_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready),
      .pop_valid   (pop_valid),
      .pop_bundle  (pop_bundle),
      .pop_ready   (pop_ready)
   );

   // Output stage: sends the bundle bytes one at a time.
   u2l_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_bundle (pop_bundle),
      .pop_ready  (pop_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
